@@ sv/npcs_pkg.sv @@
// Shared constants and types for the nearest palette color search block.
`default_nettype none

package npcs_pkg;

  localparam int PAL_ENTRIES = 256;
  localparam int ADDR_W      = $clog2(PAL_ENTRIES);
  localparam int CH_W        = 8;
  localparam int SQ_W        = 2 * CH_W;
  localparam int DIST_W      = 18;
  localparam logic [DIST_W-1:0] MAX_DIST = DIST_W'(3 * (2**CH_W - 1) * (2**CH_W - 1));

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  // travels alongside each palette entry through the distance pipeline
  typedef struct packed {
    logic              vld;
    logic              last;
    logic [ADDR_W-1:0] idx;
  } tag_t;

  typedef struct packed {
    tag_t              tag;
    logic [DIST_W-1:0] sq_dist;
  } dist_res_t;

endpackage

`default_nettype wire

@@ sv/npcs_req_if.sv @@
// Request channel: palette writes and nearest color queries.
`default_nettype none

interface npcs_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] entry_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, req_type, entry_index, red, green, blue, input ready);
  modport sink   (input valid, req_type, entry_index, red, green, blue, output ready);
endinterface

`default_nettype wire

@@ sv/npcs_rsp_if.sv @@
// Response channel: best palette index and its squared distance.
`default_nettype none

interface npcs_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  best_index;
  logic [17:0] best_distance;

  modport source (output valid, best_index, best_distance, input ready);
  modport sink   (input valid, best_index, best_distance, output ready);
endinterface

`default_nettype wire

@@ sv/nearest_palette_color_search.sv @@
// Top level: palette store, scan sequencer and running minimum.
`default_nettype none

// A query reads the 256 palette entries in index order, one per cycle, through a single
// pipelined distance unit (absolute difference, square, sum) and keeps the first entry
// with the smallest squared distance. With one memory read port and one distance unit,
// the next request is taken only after the query's result has moved into the output
// register. The request side is not ready while a query runs, nor while a finished
// query waits for an earlier response still held in the output register. A finished
// query waits in the output register, so a write may follow before the response is
// taken. Entries never written read as black through per-entry valid bits that reset
// clears at once; there is no clearing pass.
module nearest_palette_color_search (
  input wire logic  clk,
  input wire logic  rst,
  npcs_req_if.sink   req,
  npcs_rsp_if.source rsp
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_WAIT  = 2'd3;

  logic [1:0] state;
  logic       acc;
  logic [npcs_pkg::ADDR_W-1:0] scan_addr;
  logic       scan_last;

  npcs_pkg::rgb_t query;
  logic [23:0]    mem [npcs_pkg::PAL_ENTRIES];
  logic [23:0]    mem_q;
  logic [npcs_pkg::PAL_ENTRIES-1:0] pal_ok;
  logic           ok_q;
  npcs_pkg::tag_t rd_tag;
  npcs_pkg::rgb_t entry;
  npcs_pkg::dist_res_t dres;

  logic [npcs_pkg::DIST_W-1:0] best_d;
  logic [npcs_pkg::ADDR_W-1:0] best_i;
  logic                        take;
  logic                        rsp_load;
  logic                        rsp_valid;
  logic [7:0]                  rsp_idx;
  logic [17:0]                 rsp_dist;

  assign acc       = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign scan_last = (scan_addr == npcs_pkg::ADDR_W'(npcs_pkg::PAL_ENTRIES - 1));
  // finished result moves into the output register once it is free or being taken
  assign rsp_load  = (state == ST_WAIT) && (!rsp_valid || rsp.ready);

  // palette store
  always_ff @(posedge clk) begin
    if (acc && req.req_type == npcs_pkg::REQ_WRITE) begin
      mem[req.entry_index] <= {req.red, req.green, req.blue};
    end
    mem_q <= mem[scan_addr];
    ok_q  <= pal_ok[scan_addr];
  end

  assign entry = ok_q ? npcs_pkg::rgb_t'(mem_q) : '0;

  npcs_dist u_dist (
    .clk    (clk),
    .rst    (rst),
    .query  (query),
    .entry  (entry),
    .tag_in (rd_tag),
    .res    (dres)
  );

  // first result of a scan, or a strictly smaller distance, replaces the best
  assign take = dres.tag.vld && (dres.tag.idx == '0 || dres.sq_dist < best_d);

  always_ff @(posedge clk) begin
    rd_tag.last <= scan_last;
    rd_tag.idx  <= scan_addr;
    if (rst) begin
      state      <= ST_IDLE;
      scan_addr  <= '0;
      rd_tag.vld <= 1'b0;
      rsp_valid  <= 1'b0;
      pal_ok     <= '0;
    end else begin
      rd_tag.vld <= (state == ST_SCAN);
      rsp_valid  <= rsp_load || (rsp_valid && !rsp.ready);
      if (acc && req.req_type == npcs_pkg::REQ_WRITE) begin
        pal_ok[req.entry_index] <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (acc && req.req_type == npcs_pkg::REQ_QUERY) begin
            state     <= ST_SCAN;
            scan_addr <= '0;
          end
        end
        ST_SCAN: begin
          scan_addr <= scan_addr + npcs_pkg::ADDR_W'(1);
          if (scan_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (dres.tag.vld && dres.tag.last) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (rsp_load) begin
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc && req.req_type == npcs_pkg::REQ_QUERY) begin
      query <= '{r: req.red, g: req.green, b: req.blue};
    end
    if (take) begin
      best_d <= dres.sq_dist;
      best_i <= dres.tag.idx;
    end
    if (rsp_load) begin
      rsp_idx  <= 8'(best_i);
      rsp_dist <= best_d;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.best_index    = rsp_idx;
  assign rsp.best_distance = rsp_dist;

  a_rsp_from_wait: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == ST_WAIT)
    else $error("response raised outside the wait state");

  a_dist_in_scan: assert property (@(posedge clk) disable iff (rst)
    dres.tag.vld |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("distance result outside a scan");

  a_last_ends_scan: assert property (@(posedge clk) disable iff (rst)
    dres.tag.vld && dres.tag.last |=> state == ST_WAIT)
    else $error("last entry did not end the scan");

  a_dist_bound: assert property (@(posedge clk) disable iff (rst)
    dres.tag.vld |-> dres.sq_dist <= npcs_pkg::MAX_DIST)
    else $error("distance out of range");

endmodule

`default_nettype wire

@@ sv/npcs_dist.sv @@
// Three-stage squared RGB distance unit, one palette entry per cycle.
`default_nettype none

module npcs_dist (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire npcs_pkg::rgb_t     query,
  input  wire npcs_pkg::rgb_t     entry,
  input  wire npcs_pkg::tag_t     tag_in,
  output      npcs_pkg::dist_res_t res
);

  npcs_pkg::tag_t tag1, tag2, tag3;
  logic [npcs_pkg::CH_W-1:0]   dr, dg, db;
  logic [npcs_pkg::SQ_W-1:0]   sr, sg, sb;
  logic [npcs_pkg::DIST_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.vld <= 1'b0;
      tag2.vld <= 1'b0;
      tag3.vld <= 1'b0;
    end else begin
      tag1.vld <= tag_in.vld;
      tag2.vld <= tag1.vld;
      tag3.vld <= tag2.vld;
    end
    tag1.last <= tag_in.last;
    tag1.idx  <= tag_in.idx;
    tag2.last <= tag1.last;
    tag2.idx  <= tag1.idx;
    tag3.last <= tag2.last;
    tag3.idx  <= tag2.idx;
    // absolute differences
    dr <= (entry.r > query.r) ? entry.r - query.r : query.r - entry.r;
    dg <= (entry.g > query.g) ? entry.g - query.g : query.g - entry.g;
    db <= (entry.b > query.b) ? entry.b - query.b : query.b - entry.b;
    // squares
    sr <= npcs_pkg::SQ_W'(dr) * npcs_pkg::SQ_W'(dr);
    sg <= npcs_pkg::SQ_W'(dg) * npcs_pkg::SQ_W'(dg);
    sb <= npcs_pkg::SQ_W'(db) * npcs_pkg::SQ_W'(db);
    sum <= npcs_pkg::DIST_W'(sr) + npcs_pkg::DIST_W'(sg) + npcs_pkg::DIST_W'(sb);
  end

  assign res.tag     = tag3;
  assign res.sq_dist = sum;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench for nearest_palette_color_search: directed and random palette writes and queries.
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_ITEMS = 700;
  localparam int LONG_HOLD    = 3000;

  typedef struct packed {
    logic [npcs_pkg::ADDR_W-1:0] idx;
    logic [npcs_pkg::DIST_W-1:0] sq_dist;
  } nearest_t;

  logic clk;
  logic rst;

  npcs_req_if req_if();
  npcs_rsp_if rsp_if();

  nearest_palette_color_search i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  npcs_pkg::rgb_t palette_model [npcs_pkg::PAL_ENTRIES];
  nearest_t    nearest_q [$];
  int          err_cnt      = 0;
  int          n_writes     = 0;
  int          n_queries    = 0;
  int          n_exact      = 0;
  int          n_tied       = 0;
  int          n_checked    = 0;
  bit          quiet        = 1'b0;
  int          hold_off_req = 0;
  int unsigned cycle_cnt    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d responses outstanding",
               $time, cycle_cnt, nearest_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [7:0] rand_channel();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  // small offset around a stored component, clamped to the channel range
  function automatic logic [7:0] nudge(input logic [7:0] v);
    int n;
    n = int'(v) + $urandom_range(0, 4) - 2;
    if (n < 0) n = 0;
    if (n > 255) n = 255;
    return 8'(n);
  endfunction

  // full scan; only a strictly smaller distance moves the best, so ties keep the low index
  function automatic nearest_t find_nearest(input npcs_pkg::rgb_t c, output bit tied);
    nearest_t best;
    int       dr, dg, db, d, best_d;
    best   = '0;
    best_d = 0;
    tied   = 1'b0;
    for (int i = 0; i < npcs_pkg::PAL_ENTRIES; i++) begin
      dr = int'(palette_model[i].r) - int'(c.r);
      dg = int'(palette_model[i].g) - int'(c.g);
      db = int'(palette_model[i].b) - int'(c.b);
      d  = dr * dr + dg * dg + db * db;
      if (i == 0 || d < best_d) begin
        best_d   = d;
        best.idx = npcs_pkg::ADDR_W'(i);
        tied     = 1'b0;
      end else if (d == best_d) begin
        tied = 1'b1;
      end
    end
    best.sq_dist = npcs_pkg::DIST_W'(best_d);
    return best;
  endfunction

  // called at a rising edge; returns at the edge where the request is taken, valid left high
  task automatic send_request(input logic rtype, input logic [7:0] idx,
                              input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int             gap;
    bit             tied;
    npcs_pkg::rgb_t c;
    nearest_t       res;
    c   = {r, g, b};
    gap = idle_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= rtype;
    req_if.entry_index <= idx;
    req_if.red         <= r;
    req_if.green       <= g;
    req_if.blue        <= b;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    if (rtype == npcs_pkg::REQ_WRITE) begin
      palette_model[idx] = c;
      n_writes++;
    end else begin
      res = find_nearest(c, tied);
      nearest_q.push_back(res);
      n_queries++;
      if (res.sq_dist == '0) n_exact++;
      if (tied) n_tied++;
    end
  endtask

  task automatic wait_all_done();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (nearest_q.size() != 0) @(posedge clk);
  endtask

  // response side: random stalls, plus a long hold-off when a test asks for one
  initial begin : rsp_ready_drv
    int n;
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req > 0) begin
        n            = hold_off_req;
        hold_off_req = 0;
        rsp_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        n = idle_gap();
        if (n == 0) n = 1;
        rsp_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        rsp_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : rsp_check
    nearest_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (nearest_q.size() == 0) begin
        $display("%0t: unexpected response: best_index=%0d best_distance=%0d",
                 $time, rsp_if.best_index, rsp_if.best_distance);
        err_cnt++;
      end else begin
        want = nearest_q.pop_front();
        n_checked++;
        if (rsp_if.best_index !== want.idx) begin
          $display("%0t: best_index mismatch: expected %0d, actual %0d",
                   $time, want.idx, rsp_if.best_index);
          err_cnt++;
        end
        if (rsp_if.best_distance !== want.sq_dist) begin
          $display("%0t: best_distance mismatch: expected %0d, actual %0d",
                   $time, want.sq_dist, rsp_if.best_distance);
          err_cnt++;
        end
      end
    end
  end

  // all black after reset: index 0 wins every query
  task automatic test_black_palette();
    send_request(npcs_pkg::REQ_QUERY, 8'h00, 8'h00, 8'h00, 8'h00);
    send_request(npcs_pkg::REQ_QUERY, 8'hff, 8'hff, 8'hff, 8'hff);
  endtask

  task automatic test_exact_and_extremes();
    send_request(npcs_pkg::REQ_WRITE, 8'hff, 8'hff, 8'hff, 8'hff);
    send_request(npcs_pkg::REQ_QUERY, 8'h00, 8'hff, 8'hff, 8'hff);
    send_request(npcs_pkg::REQ_WRITE, 8'h01, 8'h80, 8'h80, 8'h80);
    send_request(npcs_pkg::REQ_QUERY, 8'h5a, 8'h7f, 8'h80, 8'h81);
    send_request(npcs_pkg::REQ_WRITE, 8'h00, 8'hff, 8'h00, 8'h00);
    // black now first found at index 2
    send_request(npcs_pkg::REQ_QUERY, 8'ha5, 8'h00, 8'h00, 8'h00);
    send_request(npcs_pkg::REQ_QUERY, 8'h00, 8'hff, 8'h00, 8'h00);
    send_request(npcs_pkg::REQ_QUERY, 8'h00, 8'h00, 8'hff, 8'h00);
  endtask

  task automatic test_ties();
    send_request(npcs_pkg::REQ_WRITE, 8'd40, 8'd10, 8'd20, 8'd30);
    send_request(npcs_pkg::REQ_WRITE, 8'd41, 8'd10, 8'd20, 8'd30);
    send_request(npcs_pkg::REQ_QUERY, 8'd41, 8'd10, 8'd20, 8'd30);
    // equal non-zero distance on both sides; lower index must win
    send_request(npcs_pkg::REQ_WRITE, 8'd60, 8'd100, 8'd100, 8'd100);
    send_request(npcs_pkg::REQ_WRITE, 8'd30, 8'd102, 8'd100, 8'd100);
    send_request(npcs_pkg::REQ_QUERY, 8'd60, 8'd101, 8'd100, 8'd100);
  endtask

  // response held back: a write slips in behind the parked result, then requests stall
  task automatic test_output_backpressure();
    hold_off_req = LONG_HOLD;
    send_request(npcs_pkg::REQ_QUERY, 8'h00, 8'd200, 8'd16, 8'd99);
    send_request(npcs_pkg::REQ_WRITE, 8'd77, 8'd200, 8'd16, 8'd99);
    send_request(npcs_pkg::REQ_QUERY, 8'h00, 8'd200, 8'd16, 8'd99);
    send_request(npcs_pkg::REQ_QUERY, 8'h00, 8'd201, 8'd17, 8'd98);
    wait_all_done();
  endtask

  task automatic test_random_traffic();
    int unsigned    kind;
    logic [7:0]     idx;
    npcs_pkg::rgb_t c;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) quiet = ((n / 100) % 3 == 2);
      if (n % 100 == 50) wait_all_done();
      kind = $urandom_range(0, 99);
      idx  = 8'($urandom_range(0, 255));
      c    = {rand_channel(), rand_channel(), rand_channel()};
      if (kind < 45) begin
        // bias some writes onto the lowest and highest slots
        if ($urandom_range(0, 2) == 0) idx = {{4{idx[7]}}, idx[3:0]};
        if ($urandom_range(0, 3) == 0) begin
          c = palette_model[$urandom_range(0, npcs_pkg::PAL_ENTRIES - 1)];
        end
        send_request(npcs_pkg::REQ_WRITE, idx, c.r, c.g, c.b);
      end else if (kind < 85) begin
        c = palette_model[$urandom_range(0, npcs_pkg::PAL_ENTRIES - 1)];
        if ($urandom_range(0, 2) != 0) c = {nudge(c.r), nudge(c.g), nudge(c.b)};
        send_request(npcs_pkg::REQ_QUERY, idx, c.r, c.g, c.b);
      end else begin
        send_request(npcs_pkg::REQ_QUERY, idx, c.r, c.g, c.b);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    req_if.valid       <= 1'b0;
    req_if.req_type    <= npcs_pkg::REQ_WRITE;
    req_if.entry_index <= 8'h00;
    req_if.red         <= 8'h00;
    req_if.green       <= 8'h00;
    req_if.blue        <= 8'h00;
    rst                <= 1'b1;
    for (int i = 0; i < npcs_pkg::PAL_ENTRIES; i++) palette_model[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_black_palette();
    test_exact_and_extremes();
    test_ties();
    test_output_backpressure();
    test_random_traffic();

    wait_all_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d palette writes and %0d queries (%0d exact hits, %0d tied).",
             n_writes, n_queries, n_exact, n_tied);
    $display("Checked %0d responses, including a %0d-cycle response hold-off.",
             n_checked, LONG_HOLD);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
